/* rtl/battery_monitor_frame_decoder_core_macros.svh */
// Assertion macros for the battery monitor frame decoder.
// Used by battery_monitor_frame_decoder_core.sv; relies on clk and arst_n in scope.
`ifndef BATTERY_MONITOR_FRAME_DECODER_CORE_MACROS_SVH
`define BATTERY_MONITOR_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BMFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BMFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bmfd_pkg.sv */
// Shared types and constants of the battery monitor frame decoder.
// No dependencies; used by the field unit, the top level and the testbench.
package bmfd_pkg;

	// Frame preamble, in arrival order.
	localparam logic [7:0] PREAMBLE [4] = '{8'h68, 8'h31, 8'hCE, 8'h68};
	localparam logic [7:0] PRE_FIRST = 8'h68;

	// Frame layout and checks.
	localparam int MIN_FRAME    = 10;
	localparam int LEN_OVERHEAD = 7;
	localparam int DATA_OFS     = 6;
	localparam int CMD_OFS      = 4;
	localparam int DLEN_OFS     = 5;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_BAD_LEN  = 2'd2;
	localparam logic [1:0] ST_NO_ROOM  = 2'd3;

	// Configuration register indexes.
	localparam logic [0:0] CFG_END_MARKER  = 1'd0;
	localparam logic [0:0] CFG_FRAME_LIMIT = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [7:0] END_MARKER_RST  = 8'h16;
	localparam logic [7:0] FRAME_LIMIT_RST = 8'd128;

	// How the field unit treats the field that is being assembled.
	typedef struct packed {
		logic is_byte;
		logic is_signed;
		logic is_last;
	} field_ctl_t;

endpackage

/* rtl/bmfd_if.sv */
// Valid/ready channel interfaces of the battery monitor frame decoder.
// Depends on nothing; the payload widths follow the frame decoder's fields.
interface bmfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bmfd_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [7:0]         command;
	logic [7:0]         declared_len;
	logic [7:0]         frame_len;
	logic [4:0]         field_kind;
	logic signed [16:0] field_value;
	logic               last;

	modport source (output valid, output status, output command, output declared_len,
		output frame_len, output field_kind, output field_value, output last,
		input ready);
	modport sink (input valid, input status, input command, input declared_len,
		input frame_len, input field_kind, input field_value, input last,
		output ready);
endinterface

/* rtl/bmfd_field_unit.sv */
// Shared field unit: classifies the current field and assembles its raw value.
// Depends on bmfd_pkg for field_ctl_t.
module bmfd_field_unit import bmfd_pkg::*; #(
	parameter int CELL_COUNT = 13,
	parameter int KW = 5
) (
	input  logic [KW-1:0]      kind,
	input  logic [7:0]         lo,
	input  logic [7:0]         hi,
	output field_ctl_t         ctl,
	output logic signed [16:0] value
);

	localparam logic [KW-1:0] K_CURRENT = KW'(CELL_COUNT + 1);
	localparam logic [KW-1:0] K_CHARGE  = KW'(CELL_COUNT + 2);
	localparam logic [KW-1:0] K_TEMP1   = KW'(CELL_COUNT + 3);
	localparam logic [KW-1:0] K_TEMP2   = KW'(CELL_COUNT + 4);

	always_comb begin
		ctl.is_byte   = (kind == K_CHARGE);
		ctl.is_signed = (kind == K_CURRENT) || (kind == K_TEMP1) || (kind == K_TEMP2);
		ctl.is_last   = (kind == K_TEMP2);
		if (ctl.is_byte) begin
			value = {9'd0, lo};
		end else begin
			value = {ctl.is_signed & hi[7], hi, lo};
		end
	end

endmodule

/* rtl/battery_monitor_frame_decoder_core.sv */
// Battery monitor frame decoder, top level.
// Depends on bmfd_pkg, bmfd_if.sv, bmfd_field_unit and the assertion macro header.
//
// The decoder takes one received byte per transfer on rx and hunts for the
// preamble 68 31 CE 68; a byte that breaks the match restarts the hunt and
// counts as a new first byte if it is 0x68. After the preamble it stores
// bytes until one equals end_marker or the frame reaches frame_limit bytes
// (never more than FRAME_BYTES), then checks the frame and answers on result.
// A frame under 10 bytes, one whose declared length plus 7 exceeds its
// length, or one too short for the fields gives a single error result with
// last set. A good frame gives CELL_COUNT + 5 results: the cell voltages,
// total voltage, signed current, charge and two signed temperatures. While
// hunting and capturing, rx takes one byte every cycle. At frame end rx is
// held off until the last result transfer: an error result is offered the
// cycle after the closing byte; in a good frame one shared field unit reads
// the frame store one byte per cycle while it fetches, so each two-byte field
// takes the fetch states S_LO and S_HI and the charge byte S_LO alone, and
// each result then waits in S_OUT for its transfer. The store's single read
// port sets that pace. Configuration is written through cfg_we, cfg_index and
// cfg_wdata, and takes effect at once; write it only while the decoder is
// idle.
`include "battery_monitor_frame_decoder_core_macros.svh"

module battery_monitor_frame_decoder_core import bmfd_pkg::*; #(
	parameter int FRAME_BYTES = 128,
	parameter int CELL_COUNT = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [7:0]    cfg_wdata,
	bmfd_rx_if.sink       rx,
	bmfd_result_if.source result
);

	// Width of the fill count (holds FRAME_BYTES itself), at least the byte width.
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam int CW = (FILL_W > 8) ? FILL_W : 8;
	localparam int AW = $clog2(FRAME_BYTES);
	localparam int KW = $clog2(CELL_COUNT + 5);
	localparam int KO = (KW > 5) ? KW : 5;
	localparam int NEED_BYTES = DATA_OFS + 2 * CELL_COUNT + 9;

	typedef enum logic [1:0] {
		S_RUN,
		S_LO,
		S_HI,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0] end_marker_q;
	logic [7:0] frame_limit_q;

	// Hunt and capture state.
	logic [1:0]    match_q;
	logic          capturing_q;
	logic [CW-1:0] fill_q;

	// Frame store with a registered read port.
	logic [7:0]    store_mem [FRAME_BYTES];
	logic [AW-1:0] addr_q;
	logic [AW-1:0] addr_d;
	logic [7:0]    rdata_q;
	logic          store_we;

	// Result registers.
	logic [1:0]         status_q;
	logic [7:0]         command_q;
	logic [7:0]         dlen_q;
	logic [7:0]         frame_len_q;
	logic [KO-1:0]      kind_q;
	logic signed [16:0] value_q;
	logic               last_q;
	logic [7:0]         lo_q;

	// Field unit connections.
	field_ctl_t         fctl;
	logic signed [16:0] fvalue;
	logic [7:0]         unit_lo;

	logic          rx_xfer;
	logic          res_xfer;
	logic [CW-1:0] fill_nx;
	logic [CW-1:0] limit;
	logic          frame_close;
	logic [1:0]    end_status;

	assign rx.ready  = (state_q == S_RUN);
	assign rx_xfer   = rx.valid && rx.ready;
	assign res_xfer  = result.valid && result.ready;
	assign store_we  = rx_xfer && capturing_q && (fill_q < CW'(FRAME_BYTES));

	// The fill count saturates at the store depth; the effective limit never exceeds it.
	assign fill_nx   = (fill_q < CW'(FRAME_BYTES)) ? fill_q + CW'(1) : fill_q;
	assign limit     = (CW'(frame_limit_q) > CW'(FRAME_BYTES)) ? CW'(FRAME_BYTES)
		: CW'(frame_limit_q);
	assign frame_close = (rx.rx_byte == end_marker_q) || (fill_nx >= limit);

	// Frame checks in priority order. The declared length byte is always captured
	// once the frame is at least ten bytes long.
	always_comb begin
		if (fill_nx < CW'(MIN_FRAME)) begin
			end_status = ST_SHORT;
		end else if ((CW+1)'(dlen_q) + (CW+1)'(LEN_OVERHEAD) > (CW+1)'(fill_nx)) begin
			end_status = ST_BAD_LEN;
		end else if (fill_nx < CW'(NEED_BYTES)) begin
			end_status = ST_NO_ROOM;
		end else begin
			end_status = ST_OK;
		end
	end

	// The low byte comes straight from the store for a one-byte field.
	assign unit_lo = (state_q == S_LO) ? rdata_q : lo_q;

	bmfd_field_unit #(
		.CELL_COUNT(CELL_COUNT),
		.KW(KO)
	) u_field (
		.kind(kind_q),
		.lo(unit_lo),
		.hi(rdata_q),
		.ctl(fctl),
		.value(fvalue)
	);

	// The read address steps by one for every byte that a fetch state consumes,
	// so rdata_q holds the byte at addr_q while the fields are fetched.
	always_comb begin
		addr_d = addr_q;
		unique case (state_q)
			S_RUN: begin
				if (rx_xfer && capturing_q && frame_close) begin
					addr_d = AW'(DATA_OFS);
				end
			end
			S_LO, S_HI: begin
				addr_d = addr_q + AW'(1);
			end
			S_OUT: begin
				addr_d = addr_q;
			end
			default: begin
				addr_d = addr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[fill_q[AW-1:0]] <= rx.rx_byte;
		end
		rdata_q <= store_mem[addr_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q  <= END_MARKER_RST;
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_END_MARKER:  end_marker_q <= cfg_wdata;
				CFG_FRAME_LIMIT: frame_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			match_q     <= 2'd0;
			capturing_q <= 1'b0;
			fill_q      <= '0;
			addr_q      <= '0;
			kind_q      <= '0;
			last_q      <= 1'b0;
			status_q    <= ST_OK;
			command_q   <= '0;
			dlen_q      <= '0;
			frame_len_q <= '0;
			value_q     <= '0;
			lo_q        <= '0;
		end else begin
			addr_q <= addr_d;
			unique case (state_q)
				S_RUN: begin
					if (rx_xfer && !capturing_q) begin
						if (rx.rx_byte == PREAMBLE[match_q]) begin
							if (match_q == 2'd3) begin
								capturing_q <= 1'b1;
								fill_q      <= CW'(4);
								match_q     <= 2'd0;
								dlen_q      <= '0;
							end else begin
								match_q <= match_q + 2'd1;
							end
						end else begin
							match_q <= (rx.rx_byte == PRE_FIRST) ? 2'd1 : 2'd0;
						end
					end else if (rx_xfer) begin
						if (fill_q == CW'(CMD_OFS)) begin
							command_q <= rx.rx_byte;
						end
						if (fill_q == CW'(DLEN_OFS)) begin
							dlen_q <= rx.rx_byte;
						end
						if (frame_close) begin
							capturing_q <= 1'b0;
							fill_q      <= '0;
							match_q     <= 2'd0;
							frame_len_q <= fill_nx[7:0];
							status_q    <= end_status;
							kind_q      <= '0;
							if (end_status == ST_OK) begin
								state_q <= S_LO;
							end else begin
								value_q <= '0;
								last_q  <= 1'b1;
								state_q <= S_OUT;
							end
						end else begin
							fill_q <= fill_nx;
						end
					end
				end
				S_LO: begin
					lo_q <= rdata_q;
					if (fctl.is_byte) begin
						value_q <= fvalue;
						last_q  <= fctl.is_last;
						state_q <= S_OUT;
					end else begin
						state_q <= S_HI;
					end
				end
				S_HI: begin
					value_q <= fvalue;
					last_q  <= fctl.is_last;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_xfer) begin
						if (last_q) begin
							state_q <= S_RUN;
						end else begin
							kind_q  <= kind_q + KO'(1);
							state_q <= S_LO;
						end
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	assign result.valid        = (state_q == S_OUT);
	assign result.status       = status_q;
	assign result.command      = command_q;
	assign result.declared_len = dlen_q;
	assign result.frame_len    = frame_len_q;
	assign result.field_kind   = kind_q[4:0];
	assign result.field_value  = value_q;
	assign result.last         = last_q;

	// The two sides never run at once: bytes are taken only while no result waits.
	`BMFD_ASSERT_NOW(a_no_overlap, rx.ready, !result.valid, "rx ready while a result is offered")
	// Every error result closes its frame.
	`BMFD_ASSERT_NOW(a_err_last, result.valid && (result.status != ST_OK), result.last,
		"error result without last")
	// After the final result of a frame the decoder takes bytes again.
	`BMFD_ASSERT_NEXT(a_resume, res_xfer && result.last, rx.ready,
		"decoder did not resume after the final result")
	// Within a good frame the next field is fetched, not new bytes taken.
	`BMFD_ASSERT_NEXT(a_hold_rx, res_xfer && !result.last, !rx.ready,
		"rx ready in the middle of a frame's results")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for battery_monitor_frame_decoder_core.
// Depends on bmfd_pkg and the rx/result channel interfaces in bmfd_if.sv.
// Bytes feed the decoder; the frame model, or a directed row, predicts each result.
`timescale 1ns / 100ps

module testbench;
	import bmfd_pkg::*;

	localparam int FRAME_BYTES = 128;
	localparam int CELL_COUNT = 13;
	// Bytes a frame needs before every field lies inside it.
	localparam int NEED_BYTES = DATA_OFS + 2 * CELL_COUNT + 9;
	// A good frame keeps the rx side held off after its closing byte until its results
	// are taken; this settle time covers any decoder work left when the queue empties.
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIRECTED_ROWS = 27;
	// From this row on, the directed frames run with a frame limit below the preamble.
	localparam int LOW_LIMIT_ROW = 22;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         command;
		logic [7:0]         declared_len;
		logic [7:0]         frame_len;
		logic [4:0]         field_kind;
		logic signed [16:0] field_value;
		logic               last;
	} frame_result_t;

	// One row of the directed stimulus: a byte and, where it closes a frame whose
	// answer is obvious, the single result that frame must give.
	typedef struct {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t res;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;

	bmfd_rx_if     rx_ch ();
	bmfd_result_if res_ch ();

	battery_monitor_frame_decoder_core #(
		.FRAME_BYTES(FRAME_BYTES),
		.CELL_COUNT(CELL_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx(rx_ch),
		.result(res_ch)
	);

	// 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the decoder's state and configuration.
	logic [1:0] hunt_pos = '0;
	logic       model_capturing = 1'b0;
	int unsigned fill_cnt = 0;
	logic [7:0] frame_buf [FRAME_BYTES];
	logic [7:0] cfg_end = END_MARKER_RST;
	logic [7:0] cfg_limit = FRAME_LIMIT_RST;

	// Results produced by the byte just decoded, and the results still owed by the
	// decoder, oldest first.
	frame_result_t new_results [$];
	frame_result_t results_due [$];

	int unsigned bytes_sent = 0;
	int unsigned results_made = 0;
	int fail_count = 0;
	int unsigned cycle_count = 0;

	// Idle rates in percent of cycles, and the request for a long result hold-off.
	int src_idle_pct = 34;
	int sink_idle_pct = 34;
	logic hold_req = 1'b0;

	stim_row_t directed_rows [DIRECTED_ROWS];

	function automatic logic [15:0] le16(input int unsigned ofs);
		return {frame_buf[ofs + 1], frame_buf[ofs]};
	endfunction

	// Advances the frame model by one received byte; any results that the byte
	// causes are left in new_results.
	function automatic void decode_rx_byte(input logic [7:0] b);
		int unsigned eff_limit;
		int unsigned len;
		int unsigned p;
		int k;
		logic [15:0] raw;
		frame_result_t r;

		new_results.delete();
		if (!model_capturing) begin
			// Preamble hunt. A mismatching 0x68 is already the first byte of a new try.
			if (b == PREAMBLE[hunt_pos]) begin
				if (hunt_pos == 2'd3) begin
					for (k = 0; k < 4; k++) frame_buf[k] = PREAMBLE[k];
					fill_cnt = 4;
					model_capturing = 1'b1;
					hunt_pos = '0;
				end else begin
					hunt_pos = hunt_pos + 2'd1;
				end
			end else begin
				hunt_pos = (b == PRE_FIRST) ? 2'd1 : 2'd0;
			end
			return;
		end

		if (fill_cnt < FRAME_BYTES) begin
			frame_buf[fill_cnt] = b;
			fill_cnt++;
		end
		eff_limit = (cfg_limit > FRAME_BYTES) ? FRAME_BYTES : cfg_limit;
		if (b != cfg_end && fill_cnt < eff_limit) return;

		len = fill_cnt;
		model_capturing = 1'b0;
		fill_cnt = 0;
		hunt_pos = '0;

		r.command = frame_buf[CMD_OFS];
		r.declared_len = (len > DLEN_OFS) ? frame_buf[DLEN_OFS] : 8'd0;
		r.frame_len = len[7:0];
		r.field_kind = '0;
		r.field_value = '0;
		r.last = 1'b1;

		// Checks go in order: too short, declared length too long, no room for fields.
		if (len < MIN_FRAME) begin
			r.status = ST_SHORT;
			new_results.push_back(r);
		end else if (frame_buf[DLEN_OFS] + LEN_OVERHEAD > len) begin
			r.status = ST_BAD_LEN;
			new_results.push_back(r);
		end else if (len < NEED_BYTES) begin
			r.status = ST_NO_ROOM;
			new_results.push_back(r);
		end else begin
			r.status = ST_OK;
			p = DATA_OFS + 2 * CELL_COUNT;
			for (k = 0; k < CELL_COUNT + 5; k++) begin
				r.field_kind = k[4:0];
				r.last = (k == CELL_COUNT + 4);
				if (k <= CELL_COUNT) begin
					// Cell voltages and then the total, all unsigned.
					r.field_value = {1'b0, le16(DATA_OFS + 2 * k)};
				end else if (k == CELL_COUNT + 2) begin
					r.field_value = {9'b0, frame_buf[p + 4]};
				end else begin
					raw = (k == CELL_COUNT + 1) ? le16(p + 2) : le16(p + 5 + 2 * (k - CELL_COUNT - 3));
					r.field_value = {raw[15], raw};
				end
				new_results.push_back(r);
			end
		end
	endfunction

	// Offers one byte on rx, idling at random first, and books the results it causes
	// once the transfer has happened.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
		input frame_result_t typed_res = '0);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		decode_rx_byte(b);
		results_made += new_results.size();
		if (typed) begin
			results_due.push_back(typed_res);
		end else begin
			foreach (new_results[i]) results_due.push_back(new_results[i]);
		end
	endtask

	// Stops offering bytes and waits until every booked result has come back and
	// the decoder has had time to finish anything that gives no result.
	task automatic wait_quiet();
		rx_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; the write enable stays high across
	// the pair so that it is raised and lowered only once.
	task automatic set_config(input logic [7:0] em, input logic [7:0] fl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_END_MARKER;
		cfg_wdata <= em;
		@(posedge clk);
		cfg_index <= CFG_FRAME_LIMIT;
		cfg_wdata <= fl;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_end = em;
		cfg_limit = fl;
	endtask

	// Sends one randomly shaped frame, or a burst of line noise. Frames are built to
	// close exactly at their chosen length: either with the end marker or by running
	// into the frame limit.
	task automatic send_random_frame();
		int unsigned eff;
		int unsigned kind;
		int unsigned tl;
		int unsigned dl;
		int unsigned hi;
		int unsigned n;
		int unsigned i;
		logic [7:0] b;

		eff = (cfg_limit > FRAME_BYTES) ? FRAME_BYTES : cfg_limit;
		if (eff < 5) eff = 5;
		kind = $urandom_range(99, 0);

		if (kind < 10) begin
			// A preamble broken off after a few bytes, followed by random noise.
			n = $urandom_range(3, 0);
			for (i = 0; i < n; i++) send_byte(PREAMBLE[i]);
			n = $urandom_range(6, 1);
			for (i = 0; i < n; i++) send_byte(8'($urandom_range(255, 0)));
			return;
		end

		if (kind < 60 && eff >= NEED_BYTES) begin
			// Well-formed frame with all fields present.
			hi = (eff > NEED_BYTES + 4) ? NEED_BYTES + 4 : eff;
			tl = $urandom_range(hi, NEED_BYTES);
			dl = $urandom_range(tl - LEN_OVERHEAD, 0);
		end else if (kind < 78 && eff >= MIN_FRAME) begin
			// Declared length that does not fit in the frame.
			hi = (eff > 40) ? 40 : eff;
			tl = $urandom_range(hi, MIN_FRAME);
			dl = $urandom_range(255, tl - LEN_OVERHEAD + 1);
		end else begin
			// Short frames of any declared length.
			hi = (eff > 40) ? 40 : eff;
			tl = $urandom_range(hi, 5);
			dl = $urandom_range(255, 0);
		end

		// Now and then a stray 0x68 in front, which the hunt must absorb.
		if ($urandom_range(3, 0) == 0) send_byte(PRE_FIRST);
		for (i = 0; i < 4; i++) send_byte(PREAMBLE[i]);
		for (i = 4; i < tl; i++) begin
			b = (i == DLEN_OFS) ? dl[7:0] : 8'($urandom_range(255, 0));
			if (i == tl - 1) begin
				if (tl < eff) b = cfg_end;
			end else if (b == cfg_end) begin
				b = b ^ 8'h01;
			end
			send_byte(b);
		end
	endtask

	// Result side: random ready, plus one long hold-off on request. The hold-off is
	// counted here so the sender keeps pushing bytes meanwhile.
	initial begin : result_ready_driver
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// Every result transfer is matched against the oldest booked result.
	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("result transfer with nothing due: status %0d kind %0d value %0d",
					res_ch.status, res_ch.field_kind, res_ch.field_value);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, res_ch.status);
					fail_count++;
				end
				if (res_ch.command !== want.command) begin
					$error("command: expected %0h, actual %0h", want.command, res_ch.command);
					fail_count++;
				end
				if (res_ch.declared_len !== want.declared_len) begin
					$error("declared_len: expected %0d, actual %0d", want.declared_len,
						res_ch.declared_len);
					fail_count++;
				end
				if (res_ch.frame_len !== want.frame_len) begin
					$error("frame_len: expected %0d, actual %0d", want.frame_len, res_ch.frame_len);
					fail_count++;
				end
				if (res_ch.field_kind !== want.field_kind) begin
					$error("field_kind: expected %0d, actual %0d", want.field_kind,
						res_ch.field_kind);
					fail_count++;
				end
				if (res_ch.field_value !== want.field_value) begin
					$error("field_value: expected %0d, actual %0d", want.field_value,
						res_ch.field_value);
					fail_count++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, res_ch.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		int phase;
		int unsigned budget;
		int unsigned min_results;
		int unsigned bytes_at_start;
		int unsigned results_at_start;
		logic [7:0] em;
		logic [7:0] fl;

		for (i = 0; i < FRAME_BYTES; i++) frame_buf[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_END_MARKER;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;

		// Directed frames, at the reset configuration except for the last one:
		// - a slipped preamble (68 31 68 31 CE 68) that must still lock, followed by a
		//   10-byte frame whose declared length 0xFF cannot fit;
		// - a 10-byte frame with a consistent length but no room for the fields;
		// - with the frame limit set below the preamble length, a frame that ends on
		//   the first byte after the preamble and so has no length byte at all.
		directed_rows = '{
			'{8'h68, 1'b0, '0}, '{8'h31, 1'b0, '0}, '{8'h68, 1'b0, '0},
			'{8'h31, 1'b0, '0}, '{8'hCE, 1'b0, '0}, '{8'h68, 1'b0, '0},
			'{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h55, 1'b0, '0},
			'{8'hAA, 1'b0, '0}, '{8'h01, 1'b0, '0},
			'{8'h16, 1'b1, '{ST_BAD_LEN, 8'h00, 8'hFF, 8'd10, 5'd0, 17'sd0, 1'b1}},
			'{8'h68, 1'b0, '0}, '{8'h31, 1'b0, '0}, '{8'hCE, 1'b0, '0},
			'{8'h68, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h03, 1'b0, '0},
			'{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
			'{8'h16, 1'b1, '{ST_NO_ROOM, 8'h7F, 8'h03, 8'd10, 5'd0, 17'sd0, 1'b1}},
			'{8'h68, 1'b0, '0}, '{8'h31, 1'b0, '0}, '{8'hCE, 1'b0, '0},
			'{8'h68, 1'b0, '0},
			'{8'h80, 1'b1, '{ST_SHORT, 8'h80, 8'h00, 8'd5, 5'd0, 17'sd0, 1'b1}}
		};

		// Reset is applied once, at the start of the run.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == LOW_LIMIT_ROW) begin
				wait_quiet();
				set_config(END_MARKER_RST, 8'd3);
			end
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);
		end

		// Random frames over several configurations. The first phase runs with both
		// sides always ready; the third opens with a long result hold-off so the
		// decoder backs up into rx while bytes are still being offered.
		for (phase = 0; phase < 4; phase++) begin
			src_idle_pct = 34;
			sink_idle_pct = 34;
			case (phase)
				0: begin
					em = END_MARKER_RST;
					fl = FRAME_LIMIT_RST;
					src_idle_pct = 0;
					sink_idle_pct = 0;
					budget = 40;
					min_results = CELL_COUNT + 5;
				end
				1: begin
					// Smallest end marker and a limit under the minimum frame: only short frames.
					em = 8'h00;
					fl = 8'd8;
					budget = 15;
					min_results = 0;
				end
				2: begin
					// Largest end marker and a limit above the store size.
					em = 8'hFF;
					fl = 8'hFF;
					budget = 20;
					min_results = 1;
				end
				default: begin
					em = 8'($urandom_range(255, 0));
					fl = 8'($urandom_range(FRAME_BYTES, NEED_BYTES));
					budget = 1;
					min_results = 0;
				end
			endcase
			wait_quiet();
			set_config(em, fl);
			if (phase == 2) hold_req = 1'b1;
			bytes_at_start = bytes_sent;
			results_at_start = results_made;
			do send_random_frame();
			while (bytes_sent - bytes_at_start < budget ||
				results_made - results_at_start < min_results);
			// Close any frame that noise may have opened before reconfiguring.
			while (model_capturing) send_byte(cfg_end);
			// One more byte is offered; it is taken only once the held-off results no longer block rx.
			if (phase == 2) send_byte(8'h00);
		end

		wait_quiet();
		if (fail_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bmfd_pkg.sv
rtl/bmfd_if.sv
rtl/bmfd_field_unit.sv
rtl/battery_monitor_frame_decoder_core.sv
tb/testbench.sv
